>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the key table checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define LPKT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Same-cycle implication.
`define LPKT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/lpkt_pkg.sv
// ----------------------------------------------------------------------------
// lpkt_pkg
// Types and codes shared by the linear probe key table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpkt_pkg;

   localparam int SLOTS_DEFAULT    = 1024;
   localparam int TAG_BITS_DEFAULT = 32;

   localparam int CMD_W       = 2;
   localparam int KEY_W       = 64;
   localparam int TAG_FIELD_W = 32;
   localparam int STATUS_W    = 3;
   localparam int ENT_W       = 10;

   localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNIQUE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;
   localparam logic [STATUS_W-1:0] ST_COLLISION = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;
   localparam logic [STATUS_W-1:0] ST_RESERVED  = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]       command;
      logic [KEY_W-1:0]       key;
      logic [TAG_FIELD_W-1:0] tag_handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [TAG_FIELD_W-1:0] found_tag;
      logic [ENT_W-1:0]       entries_used;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/lpkt_slot_ram.sv
// ----------------------------------------------------------------------------
// lpkt_slot_ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lpkt_slot_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/linear_probe_key_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_key_table_unit
// Open-addressing key table with linear probing and tag handles.
// ----------------------------------------------------------------------------
// Use: req_ carries one command item (lookup, insert, unique insert) with a
// 64-bit key and a tag handle; rsp_ returns one item per request with the
// status, the stored tag and the occupied slot count.
// Flow: the item is taken, then the slots are probed in turn, read through
// the key memory port; the response is registered at the end. With a
// power-of-two slot count the probe starts at the low key bits. Otherwise
// the home slot is first reduced 16 key bits at a time, with a quotient
// phase and a remainder phase per 16 bits.
// One item is in work at a time; a new item is taken while the previous
// response still waits in the output register.
// Reset: the key memory is cleared by a pass over all SLOTS slots (1024 by
// default), one slot per cycle; req_ready stays low during that pass.
// Stall: a finished item holds in the probe state (a reserved key in S_RESV),
// rereading its slot, until the output register is free; writes happen only on that release.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_key_table_unit #(
   parameter int SLOTS    = lpkt_pkg::SLOTS_DEFAULT,
   parameter int TAG_BITS = lpkt_pkg::TAG_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lpkt_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lpkt_pkg::rsp_type     rsp_item
);

   import lpkt_pkg::*;

   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS / 2 + 1);
   localparam int TAG_W   = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
   localparam bit IS_POW2 = ((1 << IDX_W) == SLOTS);
   localparam int MOD_K   = 32 + IDX_W;
   localparam logic [32:0] MOD_MUL =
      33'(((64'd1 << MOD_K) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_RESV,
      S_PROBE
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   probes_ff, probes_in;
   logic [IDX_W-1:0]   mod_r_ff, mod_r_in;
   logic [1:0]         mod_dig_ff, mod_dig_in;
   logic               mod_ph_ff, mod_ph_in;
   logic [31:0]        mod_q_ff, mod_q_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_item_ff, rsp_item_in;

   logic [IDX_W-1:0]   rd_addr;
   logic               key_wr_en;
   logic [IDX_W-1:0]   key_wr_addr;
   logic [KEY_W-1:0]   key_wr_data;
   logic               tag_wr_en;
   logic [KEY_W-1:0]   rd_key;
   logic [TAG_W-1:0]   rd_tag;

   logic               out_free;
   logic [15:0]        mod_digit;
   logic [31:0]        mod_t;
   logic [64:0]        mod_prod;
   logic [31:0]        mod_q;
   logic [47:0]        mod_qs;
   logic [IDX_W-1:0]   mod_rem;
   logic [IDX_W-1:0]   idx_nxt;
   logic               hit, empty, last, resolve, is_ins, full;

   lpkt_slot_ram #(
      .DEPTH (SLOTS),
      .WIDTH (KEY_W),
      .ADDR_W(IDX_W)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (key_wr_en),
      .wr_addr(key_wr_addr),
      .wr_data(key_wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_key)
   );

   lpkt_slot_ram #(
      .DEPTH (SLOTS),
      .WIDTH (TAG_W),
      .ADDR_W(IDX_W)
   ) u_tag_ram (
      .clock  (clock),
      .wr_en  (tag_wr_en),
      .wr_addr(idx_ff),
      .wr_data(tag_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_tag)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign mod_digit = key_ff[{mod_dig_ff, 4'd0} +: 16];
   assign mod_t     = {16'(mod_r_ff), mod_digit};
   assign mod_prod  = {33'd0, mod_t} * {32'd0, MOD_MUL};
   assign mod_q     = 32'(mod_prod >> MOD_K);
   assign mod_qs    = {16'd0, mod_q_ff} * 48'(SLOTS);
   assign mod_rem   = IDX_W'({16'd0, mod_t} - mod_qs);
   assign idx_nxt = (idx_ff == IDX_W'(SLOTS - 1)) ? '0 : idx_ff + IDX_W'(1);

   assign hit     = (rd_key == key_ff);
   assign empty   = (rd_key == EMPTY_KEY);
   assign last    = (probes_ff == IDX_W'(SLOTS - 1));
   assign resolve = hit || empty || last;
   assign is_ins  = (cmd_ff == CMD_INSERT) || (cmd_ff == CMD_UNIQUE);
   assign full    = (count_ff >= CNT_W'(SLOTS / 2));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      key_in       = key_ff;
      cmd_in       = cmd_ff;
      tag_in       = tag_ff;
      idx_in       = idx_ff;
      probes_in    = probes_ff;
      mod_r_in     = mod_r_ff;
      mod_dig_in   = mod_dig_ff;
      mod_ph_in    = mod_ph_ff;
      mod_q_in     = mod_q_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      rd_addr      = idx_ff;
      key_wr_en    = 1'b0;
      key_wr_addr  = idx_ff;
      key_wr_data  = key_ff;
      tag_wr_en    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            key_wr_en   = 1'b1;
            key_wr_addr = clr_ff;
            key_wr_data = EMPTY_KEY;
            clr_in      = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               key_in     = req_item.key;
               cmd_in     = req_item.command;
               tag_in     = req_item.tag_handle[TAG_W-1:0];
               probes_in  = '0;
               mod_r_in   = '0;
               mod_dig_in = 2'd3;
               mod_ph_in  = 1'b0;
               priority if (req_item.key == EMPTY_KEY) begin
                  state_in = S_RESV;
               end else if (IS_POW2) begin
                  rd_addr  = req_item.key[IDX_W-1:0];
                  idx_in   = req_item.key[IDX_W-1:0];
                  state_in = S_PROBE;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (!mod_ph_ff) begin
               mod_q_in  = mod_q;
               mod_ph_in = 1'b1;
            end else begin
               mod_r_in   = mod_rem;
               mod_ph_in  = 1'b0;
               mod_dig_in = mod_dig_ff - 2'd1;
               if (mod_dig_ff == 2'd0) begin
                  rd_addr  = mod_rem;
                  idx_in   = mod_rem;
                  state_in = S_PROBE;
               end
            end
         end
         S_RESV: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.status       = ST_RESERVED;
               rsp_item_in.found_tag    = '0;
               rsp_item_in.entries_used = ENT_W'(count_ff);
               state_in                 = S_IDLE;
            end
         end
         S_PROBE: begin
            priority if (!resolve) begin
               rd_addr   = idx_nxt;
               idx_in    = idx_nxt;
               probes_in = probes_ff + IDX_W'(1);
            end else if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_item_in.found_tag = '0;
               state_in              = S_IDLE;
               priority if (hit) begin
                  rsp_item_in.found_tag = TAG_FIELD_W'(rd_tag);
                  priority if (!is_ins) begin
                     rsp_item_in.status = ST_FOUND;
                  end else if (cmd_ff == CMD_UNIQUE) begin
                     rsp_item_in.status = ST_DUPLICATE;
                  end else if (rd_tag != tag_ff) begin
                     rsp_item_in.status = ST_COLLISION;
                  end else begin
                     rsp_item_in.status = ST_ALREADY;
                  end
               end else if (!is_ins) begin
                  rsp_item_in.status = ST_NOT_FOUND;
               end else if (full || !empty) begin
                  rsp_item_in.status = ST_FULL;
               end else begin
                  rsp_item_in.status    = ST_INSERTED;
                  rsp_item_in.found_tag = TAG_FIELD_W'(tag_ff);
                  key_wr_en             = 1'b1;
                  tag_wr_en             = 1'b1;
                  count_in              = count_ff + CNT_W'(1);
               end
               rsp_item_in.entries_used = ENT_W'(count_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      cmd_ff      <= cmd_in;
      tag_ff      <= tag_in;
      idx_ff      <= idx_in;
      probes_ff   <= probes_in;
      mod_r_ff    <= mod_r_in;
      mod_dig_ff  <= mod_dig_in;
      mod_ph_ff   <= mod_ph_in;
      mod_q_ff    <= mod_q_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/lpkt_checker.sv
// ----------------------------------------------------------------------------
// lpkt_checker
// Port-level checks on the key table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lpkt_checker #(
   parameter int SLOTS = lpkt_pkg::SLOTS_DEFAULT
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire lpkt_pkg::req_type req_item,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire lpkt_pkg::rsp_type rsp_item
);

   import lpkt_pkg::*;

   logic             seen_ff, seen_in;
   logic [ENT_W-1:0] prev_ff, prev_in;
   logic             no_tag_status;
   logic             req_fire;

   assign req_fire      = req_valid && req_ready && (req_item.key != '0 || 1'b1);
   assign no_tag_status = (rsp_item.status == ST_NOT_FOUND) ||
                          (rsp_item.status == ST_FULL) ||
                          (rsp_item.status == ST_RESERVED);

   always_comb begin
      seen_in = seen_ff;
      prev_in = prev_ff;
      if (rsp_valid && rsp_ready) begin
         seen_in = 1'b1;
         prev_in = rsp_item.entries_used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
      prev_ff <= prev_in;
   end

   `LPKT_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready && !req_fire |=> rsp_valid && $stable(rsp_item),
      "response item changed while stalled")

   `LPKT_ASSERT_IMPL(a_zero_tag, clock, reset, rsp_valid && no_tag_status,
      rsp_item.found_tag == '0, "tag returned with a miss status")

   `LPKT_ASSERT_IMPL(a_half_load, clock, reset, rsp_valid,
      32'(rsp_item.entries_used) <= (SLOTS / 2), "occupancy above half load")

   `LPKT_ASSERT_IMPL(a_count_hold, clock, reset,
      rsp_valid && seen_ff && (rsp_item.status != ST_INSERTED),
      rsp_item.entries_used == prev_ff, "occupancy changed without insert")

   `LPKT_ASSERT_IMPL(a_count_step, clock, reset,
      rsp_valid && seen_ff && (rsp_item.status == ST_INSERTED),
      rsp_item.entries_used == prev_ff + ENT_W'(1), "insert did not add one slot")

endmodule

bind linear_probe_key_table_unit lpkt_checker #(.SLOTS(SLOTS)) u_lpkt_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear probe key table. A directed table covers
// empty-table lookups, the reserved key, every command, present-key inserts,
// probe chains with wraparound and field extremes. Random lookups and inserts
// then fill the table up to half load. An internal table model predicts every
// response. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lpkt_pkg::*;

   localparam int SLOTS          = SLOTS_DEFAULT;
   localparam int RANDOM_PER_PH  = 438;
   localparam int DRAIN_CYCLES   = 64;
   localparam int CYCLE_LIMIT    = 8_000_000;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      req_type rq;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   logic [KEY_W-1:0]       slot_key_mdl [SLOTS];
   logic [TAG_FIELD_W-1:0] slot_tag_mdl [SLOTS];
   int unsigned            occupied_mdl;
   logic [KEY_W-1:0]       stored_keys [$];
   logic [TAG_FIELD_W-1:0] stored_tags [$];

   rsp_type     awaited_rsp [$];
   dir_row_type dir_rows [$];
   int          sender_gap_pct = 0;
   int          receiver_stall_pct = 0;
   int          fail_count = 0;
   longint      cycle_count = 0;

   linear_probe_key_table_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic rsp_type table_step(input req_type rq);
      rsp_type     r;
      int unsigned idx;
      int          n;
      bit          hit;
      bit          have_empty;
      r = '0;
      hit = 1'b0;
      have_empty = 1'b0;
      if (rq.key == EMPTY_KEY) begin
         r.status = ST_RESERVED;
      end else begin
         idx = 32'(rq.key % 64'(SLOTS));
         for (n = 0; n < SLOTS; n++) begin
            if (slot_key_mdl[idx] == rq.key) begin
               hit = 1'b1;
               break;
            end
            if (slot_key_mdl[idx] == EMPTY_KEY) begin
               have_empty = 1'b1;
               break;
            end
            idx = (idx + 1) % SLOTS;
         end
         if (rq.command == CMD_INSERT || rq.command == CMD_UNIQUE) begin
            if (hit) begin
               r.found_tag = slot_tag_mdl[idx];
               if (rq.command == CMD_UNIQUE)
                  r.status = ST_DUPLICATE;
               else if (slot_tag_mdl[idx] != rq.tag_handle)
                  r.status = ST_COLLISION;
               else
                  r.status = ST_ALREADY;
            end else if ((occupied_mdl + 1) * 2 > SLOTS || !have_empty) begin
               r.status = ST_FULL;
            end else begin
               slot_key_mdl[idx] = rq.key;
               slot_tag_mdl[idx] = rq.tag_handle;
               occupied_mdl++;
               stored_keys.insert(stored_keys.size(), rq.key);
               stored_tags.insert(stored_tags.size(), rq.tag_handle);
               r.found_tag = rq.tag_handle;
               r.status = ST_INSERTED;
            end
         end else if (hit) begin
            r.found_tag = slot_tag_mdl[idx];
            r.status = ST_FOUND;
         end else begin
            r.status = ST_NOT_FOUND;
         end
      end
      r.entries_used = occupied_mdl[ENT_W-1:0];
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      k = {$urandom, $urandom};
      if ($urandom_range(99) < 30)
         k[9:0] = 10'($urandom_range(31));
      if (k == EMPTY_KEY)
         k[0] = 1'b0;
      return k;
   endfunction

   function automatic req_type next_random_item();
      req_type it;
      int      pick;
      int      sel;
      pick = $urandom_range(99);
      sel = (stored_keys.size() > 0) ? $urandom_range(stored_keys.size() - 1) : 0;
      it.command = CMD_LOOKUP;
      it.key = fresh_key();
      it.tag_handle = $urandom;
      if (pick < 5) begin
         it.key = EMPTY_KEY;
         it.command = 2'($urandom_range(3));
      end else if (pick < 42) begin
         it.command = CMD_INSERT;
      end else if (pick < 48) begin
         it.command = CMD_UNIQUE;
      end else if (stored_keys.size() == 0) begin
         it.command = CMD_INSERT;
      end else if (pick < 58) begin
         it.command = CMD_UNIQUE;
         it.key = stored_keys[sel];
      end else if (pick < 72) begin
         it.command = CMD_INSERT;
         it.key = stored_keys[sel];
         if ($urandom_range(1))
            it.tag_handle = stored_tags[sel];
      end else if (pick < 92) begin
         it.command = $urandom_range(1) ? CMD_LOOKUP : CMD_SPARE;
         it.key = stored_keys[sel];
      end else begin
         it.command = $urandom_range(1) ? CMD_LOOKUP : CMD_SPARE;
      end
      return it;
   endfunction

   function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                   input logic [TAG_FIELD_W-1:0] tag, input logic typed,
                                   input logic [STATUS_W-1:0] st,
                                   input logic [TAG_FIELD_W-1:0] ftag,
                                   input logic [ENT_W-1:0] ent);
      dir_row_type row;
      row.rq = '{command: cmd, key: key, tag_handle: tag};
      row.typed = typed;
      row.want = '{status: st, found_tag: ftag, entries_used: ent};
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   task automatic send_item(input req_type it);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("response with no item outstanding: status %0d", rsp_item.status);
            fail_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.found_tag !== want.found_tag) begin
               $error("found_tag expected %h got %h", want.found_tag, rsp_item.found_tag);
               fail_count++;
            end
            if (rsp_item.entries_used !== want.entries_used) begin
               $error("entries_used expected %0d got %0d",
                      want.entries_used, rsp_item.entries_used);
               fail_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   initial begin : stimulus
      int      sender_phase_pct [4];
      int      receiver_phase_pct [4];
      int      i;
      int      ph;
      req_type it;
      rsp_type want;
      sender_phase_pct = '{0, 76, 0, 35};
      receiver_phase_pct = '{0, 0, 76, 35};
      for (i = 0; i < SLOTS; i++) begin
         slot_key_mdl[i] = EMPTY_KEY;
         slot_tag_mdl[i] = '0;
      end
      occupied_mdl = 0;

      add_row(CMD_LOOKUP, 64'd0, 32'd0, 1'b1, ST_NOT_FOUND, 32'd0, 10'd0);
      add_row(CMD_INSERT, EMPTY_KEY, 32'hFFFF_FFFF, 1'b1, ST_RESERVED, 32'd0, 10'd0);
      add_row(CMD_UNIQUE, EMPTY_KEY, 32'h1234_5678, 1'b1, ST_RESERVED, 32'd0, 10'd0);
      add_row(CMD_LOOKUP, EMPTY_KEY, 32'd0, 1'b1, ST_RESERVED, 32'd0, 10'd0);
      add_row(CMD_SPARE, EMPTY_KEY, 32'd0, 1'b1, ST_RESERVED, 32'd0, 10'd0);
      add_row(CMD_INSERT, 64'd0, 32'd0, 1'b1, ST_INSERTED, 32'd0, 10'd1);
      add_row(CMD_INSERT, 64'd0, 32'd0, 1'b1, ST_ALREADY, 32'd0, 10'd1);
      add_row(CMD_INSERT, 64'd0, 32'hFFFF_FFFF, 1'b1, ST_COLLISION, 32'd0, 10'd1);
      add_row(CMD_UNIQUE, 64'd0, 32'd0, 1'b1, ST_DUPLICATE, 32'd0, 10'd1);
      add_row(CMD_LOOKUP, 64'd0, 32'hDEAD_BEEF, 1'b1, ST_FOUND, 32'd0, 10'd1);
      add_row(CMD_UNIQUE, 64'hFFFF_FFFF_FFFF_FFFE, 32'hFFFF_FFFF, 1'b1,
              ST_INSERTED, 32'hFFFF_FFFF, 10'd2);
      add_row(CMD_SPARE, 64'hFFFF_FFFF_FFFF_FFFE, 32'd0, 1'b1,
              ST_FOUND, 32'hFFFF_FFFF, 10'd2);
      add_row(CMD_INSERT, 64'h400, 32'hA5A5_A5A5, 1'b0, ST_FOUND, 32'd0, 10'd0);
      add_row(CMD_INSERT, 64'h3FF, 32'h5A5A_5A5A, 1'b0, ST_FOUND, 32'd0, 10'd0);
      add_row(CMD_INSERT, 64'h7FF, 32'h0000_0001, 1'b0, ST_FOUND, 32'd0, 10'd0);
      add_row(CMD_LOOKUP, 64'h7FF, 32'd0, 1'b0, ST_FOUND, 32'd0, 10'd0);
      add_row(CMD_LOOKUP, 64'h800, 32'd0, 1'b0, ST_FOUND, 32'd0, 10'd0);
      add_row(CMD_UNIQUE, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0,
              ST_FOUND, 32'd0, 10'd0);
      add_row(CMD_INSERT, 64'h400, 32'hA5A5_A5A4, 1'b0, ST_FOUND, 32'd0, 10'd0);
      add_row(CMD_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, ST_FOUND, 32'd0, 10'd0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].rq);
         want = table_step(dir_rows[i].rq);
         awaited_rsp.insert(awaited_rsp.size(), dir_rows[i].typed ? dir_rows[i].want : want);
      end

      for (ph = 0; ph < 4; ph++) begin
         sender_gap_pct = sender_phase_pct[ph];
         receiver_stall_pct = receiver_phase_pct[ph];
         repeat (RANDOM_PER_PH) begin
            it = next_random_item();
            send_item(it);
            awaited_rsp.insert(awaited_rsp.size(), table_step(it));
         end
      end
      req_valid <= 1'b0;

      while (awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
